// ----- rtl/core/pnds_pkg.sv -----
package pnds_pkg;

    // width and ceiling of the divisor sum
    localparam int SUM_W = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

// ----- rtl/core/perfect_number_divisor_sum.sv -----
// channel   | ports                               | handshake
// ----------+-------------------------------------+--------------------------------
// command   | i_number_in                         | taken when start=1 and busy=0
// result    | o_divisor_sum, o_is_perfect         | o_done high for one cycle
//
// every candidate d from 1 to number/2 is tested by a restoring division that
// retires one dividend bit per cycle, so one candidate takes NUM_WIDTH shift steps
// and one accumulate step
// synchronous active-low reset clears the control state; the receiver cannot stall
module perfect_number_divisor_sum #(
    parameter int NUM_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [NUM_WIDTH-1:0]         i_number_in,
    output logic                         o_done,
    output logic [pnds_pkg::SUM_W-1:0]   o_divisor_sum,
    output logic                         o_is_perfect
);

    localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;
    localparam int CMP_W = (NUM_WIDTH > pnds_pkg::SUM_W) ? NUM_WIDTH : pnds_pkg::SUM_W;
    localparam int ADD_W = CMP_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ACC,
        S_FINISH
    } t_state;

    t_state                      r_state;
    logic [NUM_WIDTH-1:0]        r_num;
    logic [NUM_WIDTH-1:0]        r_half;
    logic [NUM_WIDTH-1:0]        r_d;
    logic [NUM_WIDTH-1:0]        r_shift;
    logic [NUM_WIDTH-1:0]        r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic [pnds_pkg::SUM_W-1:0]  r_acc;
    logic                        r_sat;

    logic [NUM_WIDTH:0]          n_trial;
    logic [NUM_WIDTH:0]          n_diff;
    logic [NUM_WIDTH-1:0]        n_rem;
    logic [ADD_W-1:0]            n_sum;
    logic                        n_over;
    logic                        n_perfect;

    // one restoring division step: bring in the next dividend bit
    always_comb begin
        n_trial = {r_rem, r_shift[NUM_WIDTH-1]};
        n_diff  = n_trial - {1'b0, r_d};
        if (n_trial >= {1'b0, r_d}) begin
            n_rem = n_diff[NUM_WIDTH-1:0];
        end else begin
            n_rem = n_trial[NUM_WIDTH-1:0];
        end
    end

    // accumulate with saturation check
    assign n_sum  = ADD_W'(r_acc) + ADD_W'(r_d);
    assign n_over = n_sum > ADD_W'(pnds_pkg::SUM_MAX);

    // perfect test on the finished sum
    assign n_perfect = !r_sat && (r_num != '0) && (CMP_W'(r_acc) == CMP_W'(r_num));

    assign busy = (r_state != S_IDLE);

    // sequencer, datapath registers and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_num   <= i_number_in;
                        r_half  <= i_number_in >> 1;
                        r_d     <= NUM_WIDTH'(1);
                        r_shift <= i_number_in;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_sat   <= 1'b0;
                        if ((i_number_in >> 1) == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem   <= n_rem;
                    r_shift <= r_shift << 1;
                    r_cnt   <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NUM_WIDTH - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if ((r_rem == '0) && n_over) begin
                        r_acc   <= pnds_pkg::SUM_MAX;
                        r_sat   <= 1'b1;
                        r_state <= S_FINISH;
                    end else begin
                        if (r_rem == '0) begin
                            r_acc <= n_sum[pnds_pkg::SUM_W-1:0];
                        end
                        if (r_d == r_half) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_d     <= r_d + NUM_WIDTH'(1);
                            r_shift <= r_num;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_FINISH: begin
                    o_done        <= 1'b1;
                    o_divisor_sum <= r_acc;
                    o_is_perfect  <= n_perfect;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a transaction in flight");

    // an accepted command makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // the candidate stays within 1 .. number/2 while dividing
    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_d != '0) && (r_d <= r_half)))
        else $error("candidate divisor out of range");

    // a perfect flag never comes with a zero sum
    a_perfect_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_perfect) |-> (o_divisor_sum != '0))
        else $error("perfect flag with zero sum");
`endif

endmodule
